@@ src/prj_pkg.sv @@
`timescale 1ns / 1ps
package prj_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS = 8;
    localparam int REG_W = 64;
    localparam int COORD_W = 32;
    localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };
endpackage

@@ src/project_point_by_matrix.sv @@
`timescale 1ns / 1ps
// Throughput: one point per cycle while the output is not stalled
// by m_tready low; 12 multipliers feed three 33-stage restoring
// dividers, one quotient bit per stage, sharing one divisor.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// identity matrix.
module project_point_by_matrix
    import prj_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // point_x, point_y, point_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // proj_x, proj_y, proj_z, w_was_zero, saturated, zeros
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [63:0]   cfg_data
);
    localparam int SW = 2 * COORD_W - FRAC_BITS + 2;
    localparam int NW = SW + FRAC_BITS;
    localparam int QB = COORD_W + 1;

    typedef struct packed {
        logic [SW:0]   rem;
        logic [QB-1:0] nlo;
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } lane_t;

    logic [REG_W-1:0] mat_reg [NUM_REGS];
    logic en;

    logic                       v1_reg;
    logic signed [2*COORD_W-1:0] prod_reg [4][3];
    logic                       v2_reg;
    logic signed [SW-1:0]       sum_reg [4];
    logic [QB:0]                dv_reg;
    lane_t [2:0]                ln_reg [QB+1];
    logic [SW-1:0]              dm_reg [QB+1];
    logic [QB:0]                wz_reg;
    logic                       ov_reg;
    logic [103:0]               out_reg;

    function automatic logic signed [COORD_W-1:0] ent(input logic [REG_W-1:0] m [NUM_REGS],
                                                      input int r, input int c);
        ent = m[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
    endfunction

    assign en = !ov_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) mat_reg[i] <= MAT_RESET[i];
        end else if (cfg_we) begin
            mat_reg[cfg_addr] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            dv_reg <= {dv_reg[QB-1:0], v2_reg};
            ov_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= $signed(s_tdata[r*COORD_W +: COORD_W]) * ent(mat_reg, r, c);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                sum_reg[c] <= SW'(ent(mat_reg, 3, c))
                            + SW'(prod_reg[c][0] >>> FRAC_BITS)
                            + SW'(prod_reg[c][1] >>> FRAC_BITS)
                            + SW'(prod_reg[c][2] >>> FRAC_BITS);
            end
        end
    end

    logic signed [SW-1:0] wd;
    logic [SW-1:0]        dm0;
    logic [SW-1:0]        nm0 [3];
    logic [NW-1:0]        n0 [3];
    logic [NW-1:0]        nhi [3];

    always_comb begin
        wd = (sum_reg[3] == '0) ? SW'(1) << FRAC_BITS : sum_reg[3];
        dm0 = wd[SW-1] ? SW'(-wd) : SW'(wd);
        for (int c = 0; c < 3; c++) begin
            nm0[c] = sum_reg[c][SW-1] ? SW'(-sum_reg[c]) : SW'(sum_reg[c]);
            n0[c] = {nm0[c], {FRAC_BITS{1'b0}}};
            nhi[c] = n0[c] >> QB;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dm_reg[0] <= dm0;
            wz_reg[0] <= (sum_reg[3] == '0);
            for (int c = 0; c < 3; c++) begin
                ln_reg[0][c].rem <= nhi[c][SW:0];
                ln_reg[0][c].nlo <= n0[c][QB-1:0];
                ln_reg[0][c].q <= '0;
                ln_reg[0][c].neg <= sum_reg[c][SW-1] ^ wd[SW-1];
                ln_reg[0][c].ovf <= nhi[c] >= NW'(dm0);
            end
        end
    end

    for (genvar i = 1; i <= QB; i++) begin : g_div
        lane_t [2:0] ln_next;
        logic [SW:0] t [3];
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                ln_next[c] = ln_reg[i-1][c];
                t[c] = {ln_reg[i-1][c].rem[SW-1:0], ln_reg[i-1][c].nlo[QB-1]};
                ln_next[c].nlo = {ln_reg[i-1][c].nlo[QB-2:0], 1'b0};
                if (t[c] >= {1'b0, dm_reg[i-1]}) begin
                    ln_next[c].rem = t[c] - {1'b0, dm_reg[i-1]};
                    ln_next[c].q = {ln_reg[i-1][c].q[QB-2:0], 1'b1};
                end else begin
                    ln_next[c].rem = t[c];
                    ln_next[c].q = {ln_reg[i-1][c].q[QB-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ln_reg[i] <= ln_next;
                dm_reg[i] <= dm_reg[i-1];
                wz_reg[i] <= wz_reg[i-1];
            end
        end
    end

    logic [COORD_W-1:0] res [3];
    logic [2:0]         sat;
    lane_t              lf [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lf[c] = ln_reg[QB][c];
            sat[c] = lf[c].ovf
                || (!lf[c].neg && lf[c].q[QB-1:COORD_W-1] != '0)
                || (lf[c].neg && lf[c].q > {2'b01, {(COORD_W-1){1'b0}}});
            if (sat[c]) begin
                res[c] = lf[c].neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                res[c] = lf[c].neg ? COORD_W'(-lf[c].q) : lf[c].q[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {6'd0, |sat, wz_reg[QB], res[2], res[1], res[0]};
        end
    end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import prj_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct packed {
        logic        sat;
        logic        wz;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } proj_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [63:0]   cfg_data = '0;

    logic [REG_W-1:0] matrix [NUM_REGS];
    point_t pending_points [$];
    proj_t  expected_proj [$];
    int     errors = 0;
    int     stall_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     steady = 1'b0;

    project_point_by_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [63:0] mat_entry(int r, int c);
        logic signed [31:0] e;
        e = matrix[r * 2 + c / 2][(c % 2) * 32 +: 32];
        return e;
    endfunction

    function automatic logic [31:0] divide_sat(logic signed [63:0] num,
                                               logic signed [63:0] den,
                                               inout logic sat);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q = (nm << FRAC_BITS_DEF) / dm;
        if (!neg && q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (neg && q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic proj_t project_point(point_t p);
        logic signed [63:0] pt [3];
        logic signed [63:0] sum [4];
        logic signed [63:0] prod;
        proj_t r;
        logic sat;
        pt[0] = $signed(p.x);
        pt[1] = $signed(p.y);
        pt[2] = $signed(p.z);
        for (int c = 0; c < 4; c++) begin
            sum[c] = mat_entry(3, c);
            for (int k = 0; k < 3; k++) begin
                prod = pt[k] * mat_entry(k, c);
                sum[c] += prod >>> FRAC_BITS_DEF;
            end
        end
        r.wz = (sum[3] == 0);
        if (r.wz) sum[3] = 64'sd1 << FRAC_BITS_DEF;
        sat = 1'b0;
        r.x = divide_sat(sum[0], sum[3], sat);
        r.y = divide_sat(sum[1], sum[3], sat);
        r.z = divide_sat(sum[2], sum[3], sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        point_t next_point;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_proj.push_back(project_point(
                    '{x: s_tdata[31:0], y: s_tdata[63:32], z: s_tdata[95:64]}));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                next_point = pending_points.pop_front();
                s_tdata <= {next_point.z, next_point.y, next_point.x};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        proj_t got;
        proj_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[97:0];
                if (expected_proj.size() == 0) begin
                    report_mismatch("unexpected proj_x", got.x, 32'h0);
                end else begin
                    want = expected_proj.pop_front();
                    if (got.x !== want.x) report_mismatch("proj_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("proj_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("proj_z", got.z, want.z);
                    if (got.wz !== want.wz) report_mismatch("w_was_zero", got.wz, want.wz);
                    if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(int idx, logic [63:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= 3'(idx);
        cfg_data <= value;
        matrix[idx] = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                               logic [63:0] r3, logic [63:0] r4, logic [63:0] r5,
                               logic [63:0] r6, logic [63:0] r7);
        write_reg(0, r0); write_reg(1, r1); write_reg(2, r2); write_reg(3, r3);
        write_reg(4, r4); write_reg(5, r5); write_reg(6, r6); write_reg(7, r7);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $signed($urandom_range(0, 'h3_FFFF)) - 32'sh2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_reg();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom_range(0, 2) == 0 ? $urandom : rand_coord();
        hi = $urandom_range(0, 2) == 0 ? $urandom : rand_coord();
        return {hi, lo};
    endfunction

    task automatic run_points(int count);
        for (int i = 0; i < count; i++)
            pending_points.push_back('{rand_coord(), rand_coord(), rand_coord()});
        wait (pending_points.size() == 0 && expected_proj.size() == 0 && !s_tvalid);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        foreach (matrix[i]) matrix[i] = MAT_RESET[i];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        pending_points.push_back('{32'h0, 32'h0, 32'h0});
        pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_points.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF});
        pending_points.push_back('{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
        run_points(0);

        // Perspective matrix: w follows z, so z near zero gives huge quotients
        // and z equal to zero forces the zero-divisor case.
        load_matrix(64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                    64'h0, 64'h0001_0000_0001_0000, 64'h0, 64'h0);
        pending_points.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0});
        pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
        pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
        pending_points.push_back('{32'h0003_0000, 32'h0005_0000, 32'h8000_0000});
        run_points(120);

        load_matrix('1, '1, '1, '1, '1, '1, '1, '1);
        run_points(60);
        load_matrix(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                    64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                    64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                    64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000);
        run_points(60);
        load_matrix(64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                    64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                    64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                    64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF);
        run_points(60);
        load_matrix(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        run_points(40);

        for (int phase = 0; phase < 8; phase++) begin
            load_matrix(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                        rand_reg(), rand_reg(), rand_reg(), rand_reg());
            run_points(110);
        end

        steady = 1'b1;
        load_matrix(MAT_RESET[0], MAT_RESET[1], MAT_RESET[2], MAT_RESET[3],
                    MAT_RESET[4], MAT_RESET[5], MAT_RESET[6], MAT_RESET[7]);
        run_points(100);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
